// ----- design/fisr_pkg.sv -----
// ----------------------------------------------------------------------------
// fisr_pkg
// Constants and binary32 helpers for the reciprocal square root pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

	localparam logic [31:0] MAGIC     = 32'h5f3759df;
	localparam logic [31:0] CANON_NAN = 32'h7fc00000;
	localparam logic [31:0] ONE_HALF  = 32'h3f000000;
	localparam logic [31:0] THREE_HALF = 32'h3fc00000;

	// stage operations; the last stage (y*d and NaN folding) takes the default arm
	localparam int OP_HALF = 0;
	localparam int OP_HY   = 1;
	localparam int OP_TY   = 2;
	localparam int OP_SUB  = 3;

	// unpacked operand: 24-bit significand with hidden bit, biased exponent (1 for subnormals)
	typedef struct packed {
		logic        sgn;
		logic        is_nan;
		logic        is_inf;
		logic        is_zero;
		logic signed [10:0] exp;   // value = sig * 2^(exp-150)
		logic [23:0] sig;
	} unp_t;

	function automatic unp_t unpack(input logic [31:0] b);
		unp_t u;
		u.sgn     = b[31];
		u.is_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
		u.is_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
		u.is_zero = (b[30:0] == 31'd0);
		if (b[30:23] == 8'd0) begin
			u.exp = 11'sd1;
			u.sig = {1'b0, b[22:0]};
		end else begin
			u.exp = signed'({3'b000, b[30:23]});
			u.sig = {1'b1, b[22:0]};
		end
		return u;
	endfunction

	// leading zero count of a 48-bit word
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		n = 6'd48;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 6'(47 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// Round and pack: value = mag * 2^(e-150-24) with mag 48 bits, mag != 0.
	// e is the exponent the biased result would have if mag[47] were the lead bit.
	function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e,
			input logic [47:0] mag);
		logic [5:0]  lz;
		logic [47:0] nm;
		logic signed [11:0] be;
		logic [5:0]  rs;
		logic [48:0] sh;
		logic        sticky;
		logic [24:0] man;
		logic        g;
		logic [31:0] r;
		lz = lzc48(mag);
		nm = mag << lz;
		be = e - 12'(lz);
		sticky = 1'b0;
		sh = {nm, 1'b0};
		if (be < 12'sd1) begin
			rs = (be < -12'sd48) ? 6'd49 : 6'(12'sd1 - be);
			for (int i = 0; i < 49; i++)
				if (i < rs && sh[i]) sticky = 1'b1;
			sh = sh >> rs;
			be = 12'sd0;
		end
		man = {1'b0, sh[48:25]};
		g = sh[24];
		sticky = sticky | (sh[23:0] != 24'd0);
		if (g && (sticky || man[0])) man = man + 25'd1;
		if (man[24]) begin
			man = man >> 1;
			be = be + 12'sd1;
		end else if (be == 12'sd0 && man[23]) begin
			be = 12'sd1;
		end
		if (be >= 12'sd255) r = {sgn, 8'hff, 23'd0};
		else r = {sgn, be[7:0], man[22:0]};
		return r;
	endfunction

	// right shift with the shifted-out bits ORed into bit 0
	function automatic logic [51:0] shr_sticky(input logic [51:0] v, input logic [11:0] n);
		logic [5:0]  k;
		logic [51:0] mask;
		k = (n > 12'd52) ? 6'd52 : n[5:0];
		mask = ~({52{1'b1}} << k);
		return (v >> k) | {51'd0, (v & mask) != 52'd0};
	endfunction

	// binary32 multiply, round to nearest even
	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		unp_t ua, ub;
		logic s;
		logic [47:0] p;
		logic signed [11:0] e;
		logic [31:0] r;
		ua = unpack(a);
		ub = unpack(b);
		s = a[31] ^ b[31];
		p = ua.sig * ub.sig;
		e = 12'(ua.exp) + 12'(ub.exp) - 12'sd126;
		if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) || (ub.is_inf && ua.is_zero))
			r = CANON_NAN;
		else if (ua.is_inf || ub.is_inf) r = {s, 8'hff, 23'd0};
		else if (p == 48'd0) r = {s, 31'd0};
		else r = round_pack(s, e, p);
		return r;
	endfunction

	// 1.5 - u, binary32 round to nearest even
	// Both operands sit in a 52-bit frame: bit 51 spare for the carry, the larger
	// operand's significand at [50:27], the smaller one shifted right with sticky.
	function automatic logic [31:0] fsub15(input logic [31:0] u);
		unp_t uu;
		logic signed [11:0] ediff;
		logic signed [11:0] emax;
		logic [51:0] cm, um, rm;
		logic        s;
		logic [31:0] r;
		uu = unpack(u);
		s = 1'b0;
		r = 32'd0;
		ediff = 12'sd127 - 12'(uu.exp);
		cm = {1'b0, 24'hc00000, 27'd0};
		um = {1'b0, uu.sig, 27'd0};
		if (ediff >= 12'sd0) begin
			emax = 12'sd127;
			um = shr_sticky(um, ediff);
		end else begin
			emax = 12'(uu.exp);
			cm = shr_sticky(cm, -ediff);
		end
		if (u[31]) rm = cm + um;
		else if (cm >= um) rm = cm - um;
		else begin
			rm = um - cm;
			s = 1'b1;
		end
		if (uu.is_nan) r = CANON_NAN;
		else if (uu.is_inf) r = {~u[31], 8'hff, 23'd0};
		else if (rm != 52'd0)
			r = round_pack(s, emax + 12'sd1, rm[51:4] | {47'd0, rm[3:0] != 4'd0});
		return r;
	endfunction

	function automatic logic [31:0] canon(input logic [31:0] b);
		if ((b[30:23] == 8'hff) && (b[22:0] != 23'd0)) return CANON_NAN;
		return b;
	endfunction

endpackage

// ----- design/fisr_stage.sv -----
// ----------------------------------------------------------------------------
// fisr_stage
// One stallable pipeline stage: a binary32 operand lane a and the guess lane y.
// OP selects the operation applied to lanes a and y.
// ----------------------------------------------------------------------------
module fisr_stage import fisr_pkg::*; #(
	parameter int OP = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] in_a,
	input  logic [31:0] in_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_a,
	output logic [31:0] out_y
);

	logic        v_s1;
	logic [31:0] a_s1, y_s1;
	logic [31:0] res;
	logic        adv;

	// h=0.5x, t=h*y, u=t*y, d=1.5-u, and r=y*d in the last stage
	always_comb begin
		case (OP)
			OP_HALF:       res = fmul(ONE_HALF, in_a);
			OP_HY, OP_TY:  res = fmul(in_a, in_y);
			OP_SUB:        res = fsub15(in_a);
			default:       res = canon(fmul(in_y, in_a));
		endcase
	end

	assign adv      = !v_s1 || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			a_s1 <= res;
			y_s1 <= in_y;
		end
	end

	assign out_valid = v_s1;
	assign out_a     = a_s1;
	assign out_y     = y_s1;

endmodule

// ----- design/fast_inverse_square_root.sv -----
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// Magic-constant reciprocal square root with one Newton step, binary32.
// ----------------------------------------------------------------------------
// Usage: items enter on operand_bits with valid/stall and leave on
// recip_sqrt_bits with out_valid/out_stall. Each accepted item gives
// exactly one result.
// Each item passes through the stage registers, one each for 0.5*x,
// h*y, t*y, 1.5-u and y*d, and its result is on recip_sqrt_bits while
// out_valid is high. Throughput: one item per cycle while out_stall is
// low; each stage holds one floating-point operation.
// Reset (arst_n low) empties the pipeline; no item is in flight after it.
// When the receiver stalls, the last stage holds its item and the stall
// reaches back in the same cycle through every full stage; empty stages
// still fill, so nothing is lost or repeated. NaN results are output as
// 0x7FC00000.
// ----------------------------------------------------------------------------
module fast_inverse_square_root import fisr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [31:0] operand_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] recip_sqrt_bits
);

	logic [5:0]  v;
	logic [5:0]  st;
	logic [31:0] a [6];
	logic [31:0] y [6];
	logic [31:0] shifted;

	// first guess is plain integer logic, folded into stage 0 input
	assign shifted = {operand_bits[31], operand_bits[31:1]};
	assign v[0]    = valid;
	assign a[0]    = operand_bits;
	assign y[0]    = MAGIC - shifted;
	assign stall   = st[0];

	for (genvar i = 0; i < 5; i++) begin : g_stage
		fisr_stage #(.OP(i)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[i]),
			.in_stall  (st[i]),
			.in_a      (a[i]),
			.in_y      (y[i]),
			.out_valid (v[i+1]),
			.out_stall (st[i+1]),
			.out_a     (a[i+1]),
			.out_y     (y[i+1])
		);
	end

	assign st[5]           = out_stall;
	assign out_valid       = v[5];
	assign recip_sqrt_bits = a[5];

endmodule
